// ----- rtl/core/cddc_pkg.sv -----
// ----------------------------------------------------------------------------
// cddc_pkg
// Shared codes, widths and constants for the CoDel dequeue drop controller.
// ----------------------------------------------------------------------------
package cddc_pkg;

	typedef logic [31:0] time_t;

	// Item widths
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned QB_W     = 24;
	localparam int unsigned ECN_W    = 2;
	localparam int unsigned IN_DATA_W  = 96;
	localparam int unsigned OUT_DATA_W = 72;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_USE_ECN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_L4S  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BYTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CE_THRESH = 3'd5;

	// Register reset values
	localparam logic [QB_W-1:0]   MIN_BYTES_RST = 24'd1500;
	localparam time_t             TARGET_RST    = 32'd4882;
	localparam time_t             INTERVAL_RST  = 32'd97656;
	localparam time_t             CE_THRESH_RST = 32'hFFFF_FFFF;

	// Verdict codes
	localparam logic [1:0] V_DELIVER = 2'd0;
	localparam logic [1:0] V_DROP    = 2'd1;
	localparam logic [1:0] V_MARK    = 2'd2;
	localparam logic [1:0] V_NONE    = 2'd3;

	// Mark cause codes
	localparam logic [1:0] C_NONE   = 2'd0;
	localparam logic [1:0] C_TARGET = 2'd1;
	localparam logic [1:0] C_CE     = 2'd2;

	// Drop loop phase
	localparam logic [1:0] PH_NORMAL = 2'd0;
	localparam logic [1:0] PH_ENTRY  = 2'd1;
	localparam logic [1:0] PH_LOOP   = 2'd2;

	// Inverse square root, Q0.16
	localparam logic [15:0] INV_ONE = 16'hFFFF;
	// 3.0 in the Q32 Newton term
	localparam logic [63:0] NEWTON_THREE = 64'h0000_0003_0000_0000;

endpackage

// ----- rtl/core/codel_dequeue_drop_controller_core.sv -----
// ----------------------------------------------------------------------------
// codel_dequeue_drop_controller_core
// CoDel drop/mark decision per head-of-queue packet, one shared multiplier.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: kind; tdata: sojourn, now, bytes, ECN
// m_*       out  m_tvalid/m_tready    tdata: verdict, cause, dropping, count, next drop
// cfg_*     in   cfg_wr_en            cfg_index, cfg_wdata (no read-back)
//
// Steps: accept, decide and output when no arithmetic is needed; a drop-loop
// item may also run the control law, a Newton step and the control law again.
// All multiplication goes through the one 32x32 multiplier: each
// product is registered and the next step uses it in the following cycle.
// Reset: arst_n clears all control state and sets registers to defaults.
// Stalls: a finished result sits in the output register; the next item is
// taken meanwhile, and the sequencer only waits if a second result is ready.
//
module codel_dequeue_drop_controller_core #(
	parameter int unsigned BYTE_COUNT_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave side
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [31:0] sojourn_time, [63:32] now_time, [87:64] queue_bytes,
	// [89:88] ecn_bits, [95:90] zero
	input  logic [cddc_pkg::IN_DATA_W-1:0]      s_tdata,
	// [0] kind
	input  logic                                s_tuser,
	// master side
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] verdict, [3:2] mark_cause, [4] in_dropping, [36:5] drop_count,
	// [68:37] next_drop_time, [71:69] zero
	output logic [cddc_pkg::OUT_DATA_W-1:0]     m_tdata,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [cddc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cddc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	import cddc_pkg::*;

	// Byte compare width: the field is 24 bits, the mask may be narrower
	localparam int unsigned CMP_BITS = (BYTE_COUNT_BITS < QB_W) ? BYTE_COUNT_BITS : QB_W;

	// Sequencer states
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DECIDE  = 4'd1;
	localparam logic [3:0] ST_N_SQ    = 4'd2;   // r*r
	localparam logic [3:0] ST_N_MUL   = 4'd3;   // n*r^2
	localparam logic [3:0] ST_N_SUB   = 4'd4;   // 3 - n*r^2
	localparam logic [3:0] ST_N_LO    = 4'd5;   // v low word * r
	localparam logic [3:0] ST_N_HI    = 4'd6;   // v high bits * r
	localparam logic [3:0] ST_N_END   = 4'd7;   // combine, new r
	localparam logic [3:0] ST_CL_MUL  = 4'd8;   // interval * r
	localparam logic [3:0] ST_CL_ADD  = 4'd9;   // base + product
	localparam logic [3:0] ST_LOOPCHK = 4'd10;  // drop loop re-check
	localparam logic [3:0] ST_OUT     = 4'd11;

	logic [3:0] state_q;

	// configuration
	logic            use_ecn_q, use_l4s_q;
	logic [QB_W-1:0] min_bytes_q;
	time_t           target_q, interval_q, ce_thresh_q;

	// CoDel state
	logic        dropping_q;
	time_t       count_q, last_count_q;
	logic [15:0] inv_q;
	time_t       fat_q, drop_next_q, latched_q;
	logic [1:0]  phase_q;

	// captured item
	logic            kind_q;
	time_t           soj_q, now_q;
	logic [QB_W-1:0] qb_q;
	logic [ECN_W-1:0] ecn_q;

	// work registers
	logic [1:0]  verdict_q, cause_q;
	time_t       cl_base_q;
	logic        nw_cl_q;    // run control law after the Newton step
	logic        cl_chk_q;   // re-check the loop after the control law
	logic [63:0] prod_q;
	logic [46:0] v_q;
	logic [47:0] acc_q;

	// output register
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	// ------------------------------------------------------------------
	// Decision logic
	// ------------------------------------------------------------------
	logic [1:0] ph;
	time_t      t_sel, fat_sum, diff_st, diff_tf, diff_nd, diff_ce, diff_ld;
	time_t      delta, int16, diff_win, fat_new;
	logic       below, ok, markable, mark_en, now_ge_next, lat_ge_next;
	logic       delta_ok, ce_hit, l4s_byp;
	logic [1:0] fin_v, fin_c;

	assign ph = (phase_q == PH_ENTRY || phase_q == PH_LOOP) ? phase_q : PH_NORMAL;
	// the continuing packets of a drop are judged at the latched drop time
	assign t_sel = (ph == PH_NORMAL) ? now_q : latched_q;

	assign diff_st = soj_q - target_q;
	assign below   = diff_st[31]
		|| (qb_q[CMP_BITS-1:0] < min_bytes_q[CMP_BITS-1:0]);
	assign fat_sum = t_sel + interval_q;
	assign diff_tf = t_sel - fat_q;
	assign ok      = !below && (fat_q != '0) && (diff_tf != '0) && !diff_tf[31];
	assign fat_new = below ? '0 : ((fat_q == '0) ? fat_sum : fat_q);

	assign markable = (ecn_q != '0);
	assign mark_en  = use_ecn_q && markable;

	assign diff_nd     = now_q - drop_next_q;
	assign now_ge_next = !diff_nd[31];
	assign diff_ld     = latched_q - drop_next_q;
	assign lat_ge_next = !diff_ld[31];

	// re-entry shortly after leaving: resume from the count difference
	assign delta    = count_q - last_count_q;
	assign int16    = {interval_q[27:0], 4'b0000};
	assign diff_win = diff_nd - int16;
	assign delta_ok = (delta > 32'd1) && !delta[31] && diff_win[31];

	assign diff_ce = soj_q - ce_thresh_q;
	assign ce_hit  = (diff_ce != '0) && !diff_ce[31];
	// ECT1 and CE bypass CoDel in L4S mode
	assign l4s_byp = use_l4s_q && ecn_q[0];

	// default verdict when the packet is simply delivered
	assign fin_v = (!use_l4s_q && mark_en && ce_hit) ? V_MARK : V_DELIVER;
	assign fin_c = (!use_l4s_q && mark_en && ce_hit) ? C_CE : C_NONE;

	// ------------------------------------------------------------------
	// Shared multiplier
	// ------------------------------------------------------------------
	time_t       mul_a, mul_b;
	logic [63:0] mul_p, w_sub;
	logic [15:0] nw_hi, nw_res;

	always_comb begin
		case (state_q)
			ST_N_SQ: begin
				mul_a = {16'b0, inv_q};
				mul_b = {16'b0, inv_q};
			end
			ST_N_MUL: begin
				mul_a = count_q;
				mul_b = prod_q[31:0];
			end
			ST_N_LO: begin
				mul_a = v_q[31:0];
				mul_b = {16'b0, inv_q};
			end
			ST_N_HI: begin
				mul_a = {17'b0, v_q[46:32]};
				mul_b = {16'b0, inv_q};
			end
			default: begin
				mul_a = interval_q;
				mul_b = {16'b0, inv_q};
			end
		endcase
	end

	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};
	assign w_sub = NEWTON_THREE - prod_q;
	// new r is bits 46:31 of v*r, built from the two partial products
	assign nw_hi  = acc_q[47:32] + prod_q[15:0];
	assign nw_res = {nw_hi[14:0], acc_q[31]};

	// ------------------------------------------------------------------
	// Control and state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			use_ecn_q    <= 1'b0;
			use_l4s_q    <= 1'b0;
			min_bytes_q  <= MIN_BYTES_RST;
			target_q     <= TARGET_RST;
			interval_q   <= INTERVAL_RST;
			ce_thresh_q  <= CE_THRESH_RST;
			dropping_q   <= 1'b0;
			count_q      <= '0;
			last_count_q <= '0;
			inv_q        <= INV_ONE;
			fat_q        <= '0;
			drop_next_q  <= '0;
			latched_q    <= '0;
			phase_q      <= PH_NORMAL;
			verdict_q    <= V_DELIVER;
			cause_q      <= C_NONE;
			cl_base_q    <= '0;
			nw_cl_q      <= 1'b0;
			cl_chk_q     <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_USE_ECN:   use_ecn_q   <= cfg_wdata[0];
					REG_USE_L4S:   use_l4s_q   <= cfg_wdata[0];
					REG_MIN_BYTES: min_bytes_q <= cfg_wdata[QB_W-1:0];
					REG_TARGET:    target_q    <= cfg_wdata;
					REG_INTERVAL:  interval_q  <= cfg_wdata;
					REG_CE_THRESH: ce_thresh_q <= cfg_wdata;
					default: ;
				endcase
			end

			// load a finished result, or free the register once taken
			if (state_q == ST_OUT && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DECIDE;
					end
				end

				ST_DECIDE: begin
					phase_q   <= PH_NORMAL;
					verdict_q <= fin_v;
					cause_q   <= fin_c;
					state_q   <= ST_OUT;
					if (kind_q) begin
						// queue empty
						verdict_q <= V_NONE;
						cause_q   <= C_NONE;
						if (ph == PH_NORMAL) begin
							dropping_q <= 1'b0;
						end else begin
							fat_q <= '0;
							if (ph == PH_LOOP) begin
								dropping_q <= 1'b0;
							end
						end
					end else if (ph == PH_ENTRY) begin
						fat_q <= fat_new;
					end else if (ph == PH_LOOP) begin
						fat_q <= fat_new;
						if (!ok) begin
							dropping_q <= 1'b0;
						end else begin
							// advance the schedule, then re-check
							cl_base_q <= drop_next_q;
							cl_chk_q  <= 1'b1;
							state_q   <= ST_CL_MUL;
						end
					end else if (l4s_byp) begin
						verdict_q <= ce_hit ? V_MARK : V_DELIVER;
						cause_q   <= ce_hit ? C_CE : C_NONE;
					end else begin
						fat_q <= fat_new;
						if (dropping_q) begin
							if (!ok) begin
								dropping_q <= 1'b0;
							end else if (now_ge_next) begin
								// drop loop pass at now
								count_q   <= count_q + 32'd1;
								cl_base_q <= now_q;
								cl_chk_q  <= 1'b0;
								nw_cl_q   <= mark_en;
								state_q   <= ST_N_SQ;
								if (mark_en) begin
									verdict_q <= V_MARK;
									cause_q   <= C_TARGET;
								end else begin
									verdict_q <= V_DROP;
									cause_q   <= C_NONE;
									phase_q   <= PH_LOOP;
									latched_q <= now_q;
								end
							end
						end else if (ok) begin
							// enter dropping state
							dropping_q <= 1'b1;
							cl_base_q  <= now_q;
							cl_chk_q   <= 1'b0;
							nw_cl_q    <= 1'b1;
							if (mark_en) begin
								verdict_q <= V_MARK;
								cause_q   <= C_TARGET;
							end else begin
								verdict_q <= V_DROP;
								cause_q   <= C_NONE;
								phase_q   <= PH_ENTRY;
								latched_q <= now_q;
							end
							if (delta_ok) begin
								count_q      <= delta;
								last_count_q <= delta;
								state_q      <= ST_N_SQ;
							end else begin
								count_q      <= 32'd1;
								last_count_q <= 32'd1;
								inv_q        <= INV_ONE;
								state_q      <= ST_CL_MUL;
							end
						end
					end
				end

				ST_N_SQ:  state_q <= ST_N_MUL;
				ST_N_MUL: state_q <= ST_N_SUB;
				ST_N_SUB: state_q <= ST_N_LO;
				ST_N_LO:  state_q <= ST_N_HI;
				ST_N_HI:  state_q <= ST_N_END;

				ST_N_END: begin
					inv_q   <= nw_res;
					state_q <= nw_cl_q ? ST_CL_MUL : ST_OUT;
				end

				ST_CL_MUL: state_q <= ST_CL_ADD;

				ST_CL_ADD: begin
					drop_next_q <= cl_base_q + prod_q[47:16];
					state_q     <= cl_chk_q ? ST_LOOPCHK : ST_OUT;
				end

				ST_LOOPCHK: begin
					state_q <= ST_OUT;
					if (dropping_q && lat_ge_next) begin
						// drop loop pass at the latched time
						count_q   <= count_q + 32'd1;
						cl_base_q <= latched_q;
						cl_chk_q  <= 1'b0;
						nw_cl_q   <= mark_en;
						state_q   <= ST_N_SQ;
						if (mark_en) begin
							verdict_q <= V_MARK;
							cause_q   <= C_TARGET;
						end else begin
							verdict_q <= V_DROP;
							cause_q   <= C_NONE;
							phase_q   <= PH_LOOP;
						end
					end
				end

				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			soj_q  <= s_tdata[31:0];
			now_q  <= s_tdata[63:32];
			qb_q   <= s_tdata[87:64];
			ecn_q  <= s_tdata[89:88];
		end
		prod_q <= mul_p;
		if (state_q == ST_N_SUB) begin
			v_q <= w_sub[48:2];
		end
		if (state_q == ST_N_HI) begin
			acc_q <= prod_q[47:0];
		end
		if (state_q == ST_OUT && (!m_valid_q || m_tready)) begin
			m_data_q <= {3'b000, drop_next_q, count_q, dropping_q, cause_q, verdict_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	logic [1:0] out_verdict, out_cause;
	assign out_verdict = m_data_q[1:0];
	assign out_cause   = m_data_q[3:2];

	// the drop loop only continues while in dropping state
	a_phase_dropping: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_NORMAL) |-> dropping_q)
		else $error("drop loop phase set outside dropping state");

	// a cause is only reported with a mark verdict
	a_cause_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_cause != C_NONE) |-> (out_verdict == V_MARK))
		else $error("mark cause without CE mark verdict");

	// a new result never overwrites one still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready && state_q == ST_OUT) |=> (state_q == ST_OUT))
		else $error("result register overwritten");

	// drop_next only changes at the end of a control law pass
	a_next_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(drop_next_q) |-> ($past(state_q) == ST_CL_ADD))
		else $error("next drop time changed outside control law");

endmodule

// ----- tb/codel_dequeue_drop_controller_core_test.sv -----
// ----------------------------------------------------------------------------
// codel_dequeue_drop_controller_core_test
// Self-checking bench: offers head-of-queue packets and queue-empty events,
// predicts every verdict with a local CoDel model and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import cddc_pkg::*;

typedef enum bit {KIND_PACKET, KIND_EMPTY} item_kind_e;
typedef enum logic [1:0] {ECN_NOT_ECT, ECN_ECT1, ECN_ECT0, ECN_CE} ecn_code_e;

typedef struct {
	item_kind_e      kind;
	logic [31:0]     sojourn;
	logic [31:0]     now;
	logic [QB_W-1:0] bytes;
	ecn_code_e       ecn;
} head_item_t;

// lowest field last, so the struct maps straight onto m_tdata[68:0]
typedef struct packed {
	logic [31:0] next_drop;
	logic [31:0] count;
	logic        dropping;
	logic [1:0]  cause;
	logic [1:0]  verdict;
} verdict_t;

class codel_verdict_check;
	// register copy
	bit              ecn_on;
	bit              l4s_on;
	logic [QB_W-1:0] min_q;
	logic [31:0]     target;
	logic [31:0]     interval;
	logic [31:0]     ce_thr;
	// control state
	bit              dropping;
	logic [31:0]     count;
	logic [31:0]     last_count;
	logic [15:0]     inv_sqrt;
	logic [31:0]     first_above;
	logic [31:0]     drop_next;
	logic [1:0]      phase;
	logic [31:0]     latched_now;

	verdict_t        due[$];
	int unsigned     fails;
	int unsigned     checked;

	function new();
		ecn_on = 1'b0;
		l4s_on = 1'b0;
		min_q = MIN_BYTES_RST;
		target = TARGET_RST;
		interval = INTERVAL_RST;
		ce_thr = CE_THRESH_RST;
		dropping = 1'b0;
		count = '0;
		last_count = '0;
		inv_sqrt = INV_ONE;
		first_above = '0;
		drop_next = '0;
		phase = PH_NORMAL;
		latched_now = '0;
		fails = 0;
		checked = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		case (idx)
			REG_USE_ECN:   ecn_on = val[0];
			REG_USE_L4S:   l4s_on = val[0];
			REG_MIN_BYTES: min_q = val[QB_W-1:0];
			REG_TARGET:    target = val;
			REG_INTERVAL:  interval = val;
			REG_CE_THRESH: ce_thr = val;
			default: ;
		endcase
	endfunction

	function int unsigned pending();
		return due.size();
	endfunction

	// wrapping time order on the signed 32-bit difference
	function bit later(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d != 0) && !d[31];
	endfunction

	function bit later_eq(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return !d[31];
	endfunction

	function bit earlier(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	// one Newton step of 1/sqrt(n), Q0.16 in and out
	function logic [15:0] refine(logic [15:0] r, logic [31:0] n);
		logic [31:0] inv;
		logic [31:0] inv2;
		logic [63:0] prod;
		logic [63:0] v;
		inv = {r, 16'h0000};
		prod = 64'(inv) * 64'(inv);
		inv2 = prod[63:32];
		v = NEWTON_THREE - 64'(n) * 64'(inv2);
		v = v >> 2;
		v = (v * 64'(inv)) >> 31;
		return v[31:16];
	endfunction

	function logic [31:0] next_time(logic [31:0] t);
		logic [63:0] p;
		p = 64'(interval) * 64'({inv_sqrt, 16'h0000});
		return t + p[63:32];
	endfunction

	function bit drop_ok(logic [31:0] soj, logic [QB_W-1:0] qb, logic [31:0] t);
		if (earlier(soj, target) || qb < min_q) begin
			first_above = '0;
			return 1'b0;
		end
		if (first_above == 0) begin
			first_above = t + interval;
			return 1'b0;
		end
		return later(t, first_above);
	endfunction

	// one turn of the drop loop; 1 when the packet is marked instead
	function bit loop_pass(logic [31:0] t, bit markable);
		count = count + 1;
		inv_sqrt = refine(inv_sqrt, count);
		if (ecn_on && markable) begin
			drop_next = next_time(t);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// update the model with an accepted item and queue its verdict
	function void judge_item(head_item_t it);
		verdict_t    r;
		logic [1:0]  ph;
		logic [1:0]  verdict;
		logic [1:0]  cause;
		bit          marked;
		bit          finish;
		bit          markable;
		bit          ok;
		logic [31:0] delta;

		markable = (it.ecn != ECN_NOT_ECT);
		verdict = V_DELIVER;
		cause = C_NONE;
		marked = 1'b0;
		finish = 1'b1;
		ph = (phase == PH_ENTRY || phase == PH_LOOP) ? phase : PH_NORMAL;
		phase = PH_NORMAL;

		if (it.kind == KIND_EMPTY) begin
			if (ph == PH_NORMAL) begin
				dropping = 1'b0;
			end else begin
				first_above = '0;
				if (ph == PH_LOOP)
					dropping = 1'b0;
			end
			verdict = V_NONE;
			finish = 1'b0;
		end else if (ph == PH_ENTRY) begin
			void'(drop_ok(it.sojourn, it.bytes, latched_now));
		end else if (ph == PH_LOOP) begin
			if (!drop_ok(it.sojourn, it.bytes, latched_now))
				dropping = 1'b0;
			else
				drop_next = next_time(drop_next);
			if (dropping && later_eq(latched_now, drop_next)) begin
				if (loop_pass(latched_now, markable)) begin
					verdict = V_MARK;
					cause = C_TARGET;
					marked = 1'b1;
				end else begin
					verdict = V_DROP;
					phase = PH_LOOP;
					finish = 1'b0;
				end
			end
		end else if (l4s_on && (it.ecn == ECN_ECT1 || it.ecn == ECN_CE)) begin
			if (later(it.sojourn, ce_thr)) begin
				verdict = V_MARK;
				cause = C_CE;
			end
			finish = 1'b0;
		end else begin
			ok = drop_ok(it.sojourn, it.bytes, it.now);
			if (dropping) begin
				if (!ok) begin
					dropping = 1'b0;
				end else if (later_eq(it.now, drop_next)) begin
					if (loop_pass(it.now, markable)) begin
						verdict = V_MARK;
						cause = C_TARGET;
						marked = 1'b1;
					end else begin
						verdict = V_DROP;
						phase = PH_LOOP;
						latched_now = it.now;
						finish = 1'b0;
					end
				end
			end else if (ok) begin
				if (ecn_on && markable) begin
					verdict = V_MARK;
					cause = C_TARGET;
					marked = 1'b1;
				end else begin
					verdict = V_DROP;
					phase = PH_ENTRY;
					latched_now = it.now;
					finish = 1'b0;
				end
				dropping = 1'b1;
				delta = count - last_count;
				if (delta > 1 && !delta[31] &&
						earlier(it.now - drop_next, 32'd16 * interval)) begin
					count = delta;
					inv_sqrt = refine(inv_sqrt, count);
				end else begin
					count = 32'd1;
					inv_sqrt = INV_ONE;
				end
				last_count = count;
				drop_next = next_time(it.now);
			end
		end

		if (finish && !marked) begin
			if (!l4s_on && ecn_on && markable && later(it.sojourn, ce_thr)) begin
				verdict = V_MARK;
				cause = C_CE;
			end else begin
				verdict = V_DELIVER;
				cause = C_NONE;
			end
		end

		r.verdict = verdict;
		r.cause = cause;
		r.dropping = dropping;
		r.count = count;
		r.next_drop = drop_next;
		due.push_back(r);
	endfunction

	task report(string msg);
		fails++;
		if (fails <= 40)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task check_verdict(logic [OUT_DATA_W-1:0] d);
		verdict_t want;
		verdict_t got;
		got = verdict_t'(d[68:0]);
		checked++;
		if (due.size() == 0) begin
			report($sformatf("result %0d arrived with nothing outstanding", checked));
			return;
		end
		want = due.pop_front();
		if (got.verdict !== want.verdict)
			report($sformatf("result %0d verdict got %0d want %0d",
				checked, got.verdict, want.verdict));
		if (got.cause !== want.cause)
			report($sformatf("result %0d mark_cause got %0d want %0d",
				checked, got.cause, want.cause));
		if (got.dropping !== want.dropping)
			report($sformatf("result %0d in_dropping got %0d want %0d",
				checked, got.dropping, want.dropping));
		if (got.count !== want.count)
			report($sformatf("result %0d drop_count got %0h want %0h",
				checked, got.count, want.count));
		if (got.next_drop !== want.next_drop)
			report($sformatf("result %0d next_drop_time got %0h want %0h",
				checked, got.next_drop, want.next_drop));
	endtask
endclass

module codel_dequeue_drop_controller_core_test;

	localparam int unsigned N_PHASES        = 12;
	localparam int unsigned ITEMS_PER_PHASE = 120;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned TAIL_CYCLES     = 40;
	localparam logic [31:0] BIG_SOJ         = 32'd50000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// [31:0] sojourn_time, [63:32] now_time, [87:64] queue_bytes,
	// [89:88] ecn_bits, [95:90] zero
	logic [IN_DATA_W-1:0]  s_tdata;
	// [0] kind
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [1:0] verdict, [3:2] mark_cause, [4] in_dropping, [36:5] drop_count,
	// [68:37] next_drop_time, [71:69] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	codel_verdict_check board = new();

	// idle odds in percent for each side
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	// set by the stimulus, cleared by the receiver once its long hold-off ends
	bit          hold_req;
	// running packet clock and its largest step for the current settings
	logic [31:0] clock_now;
	logic [31:0] step_cap;

	codel_dequeue_drop_controller_core #(
		.BYTE_COUNT_BITS(QB_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#1000000;
		$display("codel_dequeue_drop_controller_core verification failed");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off on request so
	// the block fills its output register and stalls its input.
	initial begin : receiver
		int unsigned stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (stall = 0; stall < HOLD_CYCLES; stall++)
					@(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Result monitor: sample on the rising edge, check in arrival order.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_verdict(m_tdata);
	end

	function automatic head_item_t head(item_kind_e k, logic [31:0] soj,
			logic [31:0] now, logic [QB_W-1:0] qb, ecn_code_e ecn);
		head_item_t it;
		it.kind = k;
		it.sojourn = soj;
		it.now = now;
		it.bytes = qb;
		it.ecn = ecn;
		return it;
	endfunction

	// Offer one item; the model sees it on the edge where it is taken.
	// tvalid is left high so back-to-back items need no second assignment.
	task automatic offer(head_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {6'b0, it.ecn, it.bytes, it.now, it.sojourn};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.judge_item(it);
	endtask

	// Stop offering and wait for every outstanding verdict.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		board.set_reg(idx, val);
	endtask

	// Block must be idle here; every register is written each time.
	task automatic set_regs(bit ecn_on, bit l4s_on, logic [QB_W-1:0] min_q,
			logic [31:0] target, logic [31:0] interval, logic [31:0] ce_thr);
		write_reg(REG_USE_ECN, 32'(ecn_on));
		write_reg(REG_USE_L4S, 32'(l4s_on));
		write_reg(REG_MIN_BYTES, 32'(min_q));
		write_reg(REG_TARGET, target);
		write_reg(REG_INTERVAL, interval);
		write_reg(REG_CE_THRESH, ce_thr);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		step_cap = interval / 8 + 2;
	endtask

	// Mostly well-formed traffic: a monotonic clock, sojourns straddling the
	// target and the CE threshold, backlog above min_bytes. One in ten items
	// is pure noise.
	task automatic next_head(output head_item_t it);
		logic [31:0] qsum;
		if ($urandom_range(99) < 10) begin
			it.kind = item_kind_e'($urandom_range(1));
			it.sojourn = $urandom;
			it.now = $urandom;
			it.bytes = QB_W'($urandom);
			it.ecn = ecn_code_e'($urandom_range(3));
		end else begin
			clock_now = clock_now + $urandom_range(0, step_cap);
			it.kind = ($urandom_range(99) < 4) ? KIND_EMPTY : KIND_PACKET;
			it.now = clock_now;
			case ($urandom_range(4))
				0: it.sojourn = board.target - $urandom_range(0, 20);
				1: it.sojourn = board.target + $urandom_range(0, 20);
				2: it.sojourn = board.target + $urandom_range(0, step_cap);
				3: it.sojourn = board.ce_thr + $urandom_range(0, 20) - 32'd10;
				default: it.sojourn = $urandom;
			endcase
			if ($urandom_range(99) < 85) begin
				qsum = 32'(board.min_q) + $urandom_range(0, 2000);
				it.bytes = (qsum > 32'h00FF_FFFF) ? {QB_W{1'b1}} : qsum[QB_W-1:0];
			end else begin
				it.bytes = QB_W'($urandom);
			end
			it.ecn = ecn_code_e'($urandom_range(3));
		end
	endtask

	initial begin : stimulus
		head_item_t  it;
		int unsigned p;
		int unsigned n;

		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_USE_ECN;
		cfg_wdata = '0;
		hold_req = 1'b0;
		tx_idle_pct = 17;
		rx_idle_pct = 69;
		clock_now = '0;
		step_cap = INTERVAL_RST / 8 + 2;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed walk at reset settings: empty events in every phase, entry
		// into dropping, the drop loop, leaving it, and time wrap.
		offer(head(KIND_EMPTY, '0, '0, '0, ECN_NOT_ECT));
		offer(head(KIND_PACKET, '0, '0, '0, ECN_NOT_ECT));
		offer(head(KIND_PACKET, '1, 32'd100, '1, ECN_CE));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd200, '1, ECN_ECT0));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd200000, '1, ECN_NOT_ECT));
		offer(head(KIND_EMPTY, BIG_SOJ, 32'd200000, '1, ECN_NOT_ECT));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd300000, '1, ECN_ECT1));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd500000, '1, ECN_NOT_ECT));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd500000, '1, ECN_NOT_ECT));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd600000, '1, ECN_NOT_ECT));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd600000, '1, ECN_ECT0));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd700000, '1, ECN_NOT_ECT));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd700000, '1, ECN_NOT_ECT));
		offer(head(KIND_EMPTY, BIG_SOJ, 32'd700000, '1, ECN_NOT_ECT));
		offer(head(KIND_PACKET, BIG_SOJ, 32'd800000, '0, ECN_NOT_ECT));
		offer(head(KIND_PACKET, '0, 32'hFFFF_FFF0, '1, ECN_NOT_ECT));
		offer(head(KIND_PACKET, BIG_SOJ, '1, '1, ECN_NOT_ECT));
		offer(head(KIND_PACKET, BIG_SOJ, 32'h0002_0000, '1, ECN_NOT_ECT));
		offer(head(KIND_EMPTY, BIG_SOJ, 32'h0002_0000, '1, ECN_NOT_ECT));
		drain();

		// L4S bypass: ECT1 above and CE below a low CE threshold
		set_regs(1'b1, 1'b1, MIN_BYTES_RST, TARGET_RST, INTERVAL_RST, 32'd1000);
		offer(head(KIND_PACKET, 32'd2000, 32'h0010_0000, '1, ECN_ECT1));
		offer(head(KIND_PACKET, 32'd10, 32'h0010_0000, '1, ECN_CE));
		drain();

		// ECN marking: CE threshold mark, then a mark on entering dropping
		set_regs(1'b1, 1'b0, MIN_BYTES_RST, TARGET_RST, INTERVAL_RST, 32'd1000);
		offer(head(KIND_PACKET, 32'd2000, 32'h0020_0000, '1, ECN_ECT0));
		offer(head(KIND_PACKET, BIG_SOJ, 32'h0020_0000, '1, ECN_ECT0));
		offer(head(KIND_PACKET, BIG_SOJ, 32'h0030_0000, '1, ECN_ECT0));
		drain();

		// Random phases. Idle mix: sender light / receiver heavy, then the
		// reverse, then no idling at all.
		for (p = 0; p < N_PHASES; p++) begin
			if (p < N_PHASES / 3) begin
				tx_idle_pct = 17;
				rx_idle_pct = 69;
			end else if (p < 2 * N_PHASES / 3) begin
				tx_idle_pct = 69;
				rx_idle_pct = 17;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			if (p == 1)
				set_regs(1'b0, 1'b0, '0, '0, '0, '0);
			else if (p == 5)
				set_regs(1'b1, 1'b1, '1, '1, '1, '1);
			else if (p == 9)
				set_regs(1'b0, 1'b0, MIN_BYTES_RST, TARGET_RST, INTERVAL_RST,
					CE_THRESH_RST);
			else
				set_regs(1'($urandom_range(1)), 1'($urandom_range(1)),
					QB_W'($urandom_range(0, 3000)), $urandom_range(1, 300),
					$urandom_range(20, 3000),
					$urandom_range(1) ? 32'($urandom_range(1, 800)) : 32'hFFFF_FFFF);

			// some phases start just short of the clock wrap
			clock_now = (p % 3 == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;

			// long receiver hold-off while the sender keeps offering
			if (p == 2)
				hold_req = 1'b1;

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				next_head(it);
				offer(it);
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.fails == 0 && board.pending() == 0)
			$display("codel_dequeue_drop_controller_core verification clean");
		else
			$display("codel_dequeue_drop_controller_core verification failed");
		$finish;
	end

endmodule
